### rtl/pmp_pkg.sv
`default_nettype none

package pmp_pkg;

    localparam int DIV_NUM_W = 80;
    localparam int DIV_DEN_W = 64;
    localparam int DIV_CNT_W = 7;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FEW      = 2'd1;
    localparam logic [1:0] STATUS_ZERO     = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
        logic [DIV_DEN_W-1:0] rem;
    } div_resp_t;

    typedef struct packed {
        logic signed [63:0] sum;
        logic               ov;
    } sat_sum_t;

    function automatic sat_sum_t sat_add(input logic signed [63:0] a,
                                         input logic signed [63:0] b);
        logic signed [64:0] s;
        sat_sum_t           r;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            r.ov  = 1'b1;
            r.sum = s[64] ? SUM_MIN : SUM_MAX;
        end else begin
            r.ov  = 1'b0;
            r.sum = s[63:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/pmp_divider.sv
`default_nettype none

module pmp_divider (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  pmp_pkg::div_req_t   req,
    output pmp_pkg::div_resp_t  resp
);
    import pmp_pkg::*;

    logic [DIV_DEN_W:0]   rem_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 fits;

    // restoring division, one quotient bit a cycle
    assign rem_sh  = {rem_reg[DIV_DEN_W-1:0], quo_reg[DIV_NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, req.den};
    assign fits    = rem_sh >= {1'b0, req.den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= req.num;
            end else if (busy_reg) begin
                rem_reg <= fits ? rem_sub : rem_sh;
                quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign resp.done = done_reg;
    assign resp.quo  = quo_reg;
    assign resp.rem  = rem_reg[DIV_DEN_W-1:0];

endmodule

`default_nettype wire

### rtl/polygon_mass_properties.sv
// the first vertex is only stored; each later one adds an edge term, and from
// the third on a fan triangle, all through the single shared 36x36 multiplier
// with three or more vertices the last adds the closing edge and up to three
// 80-step divisions in the shared divider before the result is offered
// synchronous active-low reset clears the sums, counters and output valid
`default_nettype none

module polygon_mass_properties #(
    parameter int MAX_VERTICES = 64
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire signed [15:0]  s_vertex_x,
    input  wire signed [15:0]  s_vertex_y,
    input  wire        [31:0]  s_body_mass,
    input  wire                s_last_vertex,
    output logic               m_valid,
    input  wire                m_ready,
    output logic signed [15:0] m_centroid_x,
    output logic signed [15:0] m_centroid_y,
    output logic signed [63:0] m_inertia,
    output logic        [1:0]  m_status
);
    import pmp_pkg::*;

    localparam logic [6:0] MAX_CNT = 7'(MAX_VERTICES);

    typedef enum logic [4:0] {
        ST_IDLE, ST_UPD,
        ST_E_BXCY, ST_E_BYCX, ST_E_BXBX, ST_E_BYBY, ST_E_CXCX, ST_E_CYCY,
        ST_E_BXCX, ST_E_BYCY, ST_E_QSUM, ST_E_MAG, ST_E_ADD,
        ST_F_D1, ST_F_D2, ST_F_CR, ST_F_WX, ST_F_WY, ST_F_ACC,
        ST_FIN, ST_CHK, ST_DIV_CX, ST_DIV_CY, ST_DIV_L,
        ST_M_CX, ST_M_CY, ST_M_NC, ST_M_ML, ST_M_MN, ST_M_DONE, ST_OUT
    } state_t;

    state_t             state_reg;
    logic signed [15:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic signed [15:0] cur_x_reg, cur_y_reg;
    logic        [31:0] mass_reg;
    logic               last_reg;
    logic               fin_reg;
    logic        [6:0]  count_reg;
    logic signed [63:0] fan_reg, wsx_reg, wsy_reg, isum_reg;
    logic               ov_reg;
    logic signed [71:0] prod_reg;
    logic signed [35:0] cr_reg, q_reg;
    logic signed [63:0] tmp_reg;
    logic signed [15:0] cx_reg, cy_reg;
    logic        [30:0] l_reg;
    logic               m_valid_reg;

    logic signed [35:0] mul_a, mul_b;
    logic signed [35:0] abs_cr, fan_diff, fan_w;
    logic        [63:0] edge_mag;
    logic signed [63:0] edge_val;
    sat_sum_t           sat_i, sat_x, sat_y, sat_f;
    logic        [63:0] fan3, fan6, mag_x, mag_y, mag_i;
    logic               ovx;
    div_req_t           div_req;
    div_resp_t          div_resp;

    function automatic logic signed [35:0] sx36(input logic signed [15:0] v);
        return {{20{v[15]}}, v};
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : v;
    endfunction

    // rounding half away from zero, then clamp to 16 bit
    function automatic logic signed [15:0] round_sat(input logic neg,
                                                     input logic [63:0] q,
                                                     input logic [63:0] r,
                                                     input logic [63:0] den);
        logic [64:0] qr;
        logic [15:0] res;
        qr = {1'b0, q} + {64'b0, (r >= den - r)};
        if (neg) begin
            res = (qr > 65'd32768) ? 16'h8000 : 16'(65'd0 - qr);
        end else begin
            res = (qr > 65'd32767) ? 16'h7FFF : qr[15:0];
        end
        return signed'(res);
    endfunction

    assign abs_cr   = cr_reg[35] ? -cr_reg : cr_reg;
    assign fan_diff = cr_reg - prod_reg[35:0];
    assign fan_w    = fan_diff[35] ? -fan_diff : fan_diff;
    assign edge_mag = {16'b0, prod_reg[63:16]};
    assign edge_val = cr_reg[35] ? 64'(-signed'(edge_mag)) : signed'(edge_mag);
    assign sat_i    = sat_add(isum_reg, edge_val);
    assign sat_x    = sat_add(wsx_reg, prod_reg[63:0]);
    assign sat_y    = sat_add(wsy_reg, prod_reg[63:0]);
    assign sat_f    = sat_add(fan_reg, {{28{cr_reg[35]}}, cr_reg});
    assign fan3     = fan_reg + {fan_reg[62:0], 1'b0};
    assign fan6     = {fan3[62:0], 1'b0};
    assign mag_x    = mag64(wsx_reg);
    assign mag_y    = mag64(wsy_reg);
    assign mag_i    = mag64(isum_reg);
    assign ovx      = ov_reg || (fan_reg[63:44] != '0);

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_E_BXCY: begin mul_a = sx36(prev_x_reg); mul_b = sx36(cur_y_reg); end
            ST_E_BYCX: begin mul_a = sx36(prev_y_reg); mul_b = sx36(cur_x_reg); end
            ST_E_BXBX: begin mul_a = sx36(prev_x_reg); mul_b = sx36(prev_x_reg); end
            ST_E_BYBY: begin mul_a = sx36(prev_y_reg); mul_b = sx36(prev_y_reg); end
            ST_E_CXCX: begin mul_a = sx36(cur_x_reg); mul_b = sx36(cur_x_reg); end
            ST_E_CYCY: begin mul_a = sx36(cur_y_reg); mul_b = sx36(cur_y_reg); end
            ST_E_BXCX: begin mul_a = sx36(prev_x_reg); mul_b = sx36(cur_x_reg); end
            ST_E_BYCY: begin mul_a = sx36(prev_y_reg); mul_b = sx36(cur_y_reg); end
            ST_E_MAG:  begin mul_a = abs_cr; mul_b = q_reg; end
            ST_F_D1: begin
                mul_a = sx36(prev_x_reg) - sx36(first_x_reg);
                mul_b = sx36(cur_y_reg) - sx36(first_y_reg);
            end
            ST_F_D2: begin
                mul_a = sx36(prev_y_reg) - sx36(first_y_reg);
                mul_b = sx36(cur_x_reg) - sx36(first_x_reg);
            end
            ST_F_WX: begin
                mul_a = cr_reg;
                mul_b = sx36(first_x_reg) + sx36(prev_x_reg) + sx36(cur_x_reg);
            end
            ST_F_WY: begin
                mul_a = cr_reg;
                mul_b = sx36(first_y_reg) + sx36(prev_y_reg) + sx36(cur_y_reg);
            end
            ST_M_CX: begin mul_a = sx36(cx_reg); mul_b = sx36(cx_reg); end
            ST_M_CY: begin mul_a = sx36(cy_reg); mul_b = sx36(cy_reg); end
            ST_M_ML: begin mul_a = {4'b0, mass_reg}; mul_b = {5'b0, l_reg}; end
            ST_M_MN: begin mul_a = {4'b0, mass_reg}; mul_b = q_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // divider requests: centroid x, centroid y, then the inertia ratio
    // the divisor has to hold for the whole run of each division
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = fan3;
        case (state_reg)
            ST_CHK: begin
                div_req.start = (fan_reg != '0);
                div_req.num   = {16'b0, mag_x};
            end
            ST_DIV_CX: begin
                div_req.start = div_resp.done;
                div_req.num   = {16'b0, mag_y};
            end
            ST_DIV_CY: begin
                div_req.start = div_resp.done && !ovx;
                div_req.num   = {mag_i, 16'b0};
            end
            ST_DIV_L: div_req.den = fan6;
            default: div_req.start = 1'b0;
        endcase
    end

    pmp_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .resp    (div_resp)
    );

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            count_reg   <= '0;
            fan_reg     <= '0;
            wsx_reg     <= '0;
            wsy_reg     <= '0;
            isum_reg    <= '0;
            ov_reg      <= 1'b0;
            fin_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cur_x_reg <= s_vertex_x;
                        cur_y_reg <= s_vertex_y;
                        mass_reg  <= s_body_mass;
                        last_reg  <= s_last_vertex;
                        if (count_reg < MAX_CNT) begin
                            if (count_reg == '0) begin
                                first_x_reg <= s_vertex_x;
                                first_y_reg <= s_vertex_y;
                                state_reg   <= ST_UPD;
                            end else begin
                                state_reg <= ST_E_BXCY;
                            end
                        end else begin
                            // vertex beyond the limit: only its flag and mass count
                            state_reg <= s_last_vertex ? ST_FIN : ST_IDLE;
                        end
                    end
                end
                ST_UPD: begin
                    prev_x_reg <= cur_x_reg;
                    prev_y_reg <= cur_y_reg;
                    count_reg  <= count_reg + 1'b1;
                    state_reg  <= last_reg ? ST_FIN : ST_IDLE;
                end
                ST_E_BXCY: state_reg <= ST_E_BYCX;
                ST_E_BYCX: begin
                    cr_reg    <= prod_reg[35:0];
                    state_reg <= ST_E_BXBX;
                end
                ST_E_BXBX: begin
                    cr_reg    <= cr_reg - prod_reg[35:0];
                    state_reg <= ST_E_BYBY;
                end
                ST_E_BYBY: begin
                    q_reg     <= prod_reg[35:0];
                    state_reg <= ST_E_CXCX;
                end
                ST_E_CXCX: begin
                    q_reg     <= q_reg + prod_reg[35:0];
                    state_reg <= ST_E_CYCY;
                end
                ST_E_CYCY: begin
                    q_reg     <= q_reg + prod_reg[35:0];
                    state_reg <= ST_E_BXCX;
                end
                ST_E_BXCX: begin
                    q_reg     <= q_reg + prod_reg[35:0];
                    state_reg <= ST_E_BYCY;
                end
                ST_E_BYCY: begin
                    q_reg     <= q_reg + prod_reg[35:0];
                    state_reg <= ST_E_QSUM;
                end
                ST_E_QSUM: begin
                    q_reg     <= q_reg + prod_reg[35:0];
                    state_reg <= ST_E_MAG;
                end
                ST_E_MAG: state_reg <= ST_E_ADD;
                ST_E_ADD: begin
                    isum_reg <= sat_i.sum;
                    ov_reg   <= ov_reg | sat_i.ov;
                    if (fin_reg) begin
                        state_reg <= ST_CHK;
                    end else if (count_reg >= 7'd2) begin
                        state_reg <= ST_F_D1;
                    end else begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_F_D1: state_reg <= ST_F_D2;
                ST_F_D2: begin
                    cr_reg    <= prod_reg[35:0];
                    state_reg <= ST_F_CR;
                end
                ST_F_CR: begin
                    cr_reg    <= fan_w;
                    state_reg <= ST_F_WX;
                end
                ST_F_WX: state_reg <= ST_F_WY;
                ST_F_WY: begin
                    wsx_reg   <= sat_x.sum;
                    ov_reg    <= ov_reg | sat_x.ov;
                    state_reg <= ST_F_ACC;
                end
                ST_F_ACC: begin
                    wsy_reg   <= sat_y.sum;
                    fan_reg   <= sat_f.sum;
                    ov_reg    <= ov_reg | sat_y.ov | sat_f.ov;
                    state_reg <= ST_UPD;
                end
                ST_FIN: begin
                    if (count_reg < 7'd3) begin
                        m_centroid_x <= '0;
                        m_centroid_y <= '0;
                        m_inertia    <= '0;
                        m_status     <= STATUS_FEW;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= ST_OUT;
                    end else begin
                        // closing edge runs through the same edge sequence
                        cur_x_reg <= first_x_reg;
                        cur_y_reg <= first_y_reg;
                        fin_reg   <= 1'b1;
                        state_reg <= ST_E_BXCY;
                    end
                end
                ST_CHK: begin
                    if (fan_reg == '0) begin
                        m_centroid_x <= '0;
                        m_centroid_y <= '0;
                        m_inertia    <= '0;
                        m_status     <= STATUS_ZERO;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= ST_OUT;
                    end else begin
                        state_reg <= ST_DIV_CX;
                    end
                end
                ST_DIV_CX: begin
                    if (div_resp.done) begin
                        cx_reg    <= round_sat(wsx_reg[63], div_resp.quo[63:0],
                                               div_resp.rem, fan3);
                        state_reg <= ST_DIV_CY;
                    end
                end
                ST_DIV_CY: begin
                    if (div_resp.done) begin
                        cy_reg <= round_sat(wsy_reg[63], div_resp.quo[63:0],
                                            div_resp.rem, fan3);
                        if (ovx) begin
                            m_centroid_x <= cx_reg;
                            m_centroid_y <= round_sat(wsy_reg[63], div_resp.quo[63:0],
                                                      div_resp.rem, fan3);
                            m_inertia    <= SUM_MAX;
                            m_status     <= STATUS_OVERFLOW;
                            m_valid_reg  <= 1'b1;
                            state_reg    <= ST_OUT;
                        end else begin
                            state_reg <= ST_DIV_L;
                        end
                    end
                end
                ST_DIV_L: begin
                    if (div_resp.done) begin
                        l_reg <= div_resp.quo[30:0];
                        if (div_resp.quo[DIV_NUM_W-1:31] != '0) begin
                            m_centroid_x <= cx_reg;
                            m_centroid_y <= cy_reg;
                            m_inertia    <= SUM_MAX;
                            m_status     <= STATUS_OVERFLOW;
                            m_valid_reg  <= 1'b1;
                            state_reg    <= ST_OUT;
                        end else begin
                            state_reg <= ST_M_CX;
                        end
                    end
                end
                ST_M_CX: state_reg <= ST_M_CY;
                ST_M_CY: begin
                    q_reg     <= prod_reg[35:0];
                    state_reg <= ST_M_NC;
                end
                ST_M_NC: begin
                    q_reg     <= q_reg + prod_reg[35:0];
                    state_reg <= ST_M_ML;
                end
                ST_M_ML: state_reg <= ST_M_MN;
                ST_M_MN: begin
                    tmp_reg   <= prod_reg[63:0];
                    state_reg <= ST_M_DONE;
                end
                ST_M_DONE: begin
                    m_centroid_x <= cx_reg;
                    m_centroid_y <= cy_reg;
                    m_inertia    <= tmp_reg - prod_reg[63:0];
                    m_status     <= STATUS_OK;
                    m_valid_reg  <= 1'b1;
                    state_reg    <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        first_x_reg <= '0;
                        first_y_reg <= '0;
                        prev_x_reg  <= '0;
                        prev_y_reg  <= '0;
                        count_reg   <= '0;
                        fan_reg     <= '0;
                        wsx_reg     <= '0;
                        wsy_reg     <= '0;
                        isum_reg    <= '0;
                        ov_reg      <= 1'b0;
                        fin_reg     <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    a_clear_after_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> (count_reg == '0 && !ov_reg && fan_reg == '0))
        else $error("polygon state not cleared after result transaction");

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_CNT)
        else $error("vertex count beyond limit");
`endif

endmodule

`default_nettype wire

### tb/polygon_mass_properties_tb.sv
`timescale 1ns / 1ps

module polygon_mass_properties_tb;
    import pmp_pkg::*;

    localparam int  VERTEX_LIMIT = 64;
    localparam int  CYCLE_LIMIT  = 3000000;
    localparam real TWO_PI       = 6.283185307179586;

    typedef struct {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [63:0] inertia;
        logic [1:0]         status;
    } mass_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    wire                s_ready;
    logic signed [15:0] s_vertex_x = '0;
    logic signed [15:0] s_vertex_y = '0;
    logic [31:0]        s_body_mass = '0;
    logic               s_last_vertex = 1'b0;
    wire                m_valid;
    logic               m_ready = 1'b0;
    wire signed [15:0]  m_centroid_x;
    wire signed [15:0]  m_centroid_y;
    wire signed [63:0]  m_inertia;
    wire [1:0]          m_status;

    polygon_mass_properties #(.MAX_VERTICES(VERTEX_LIMIT)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_vertex_x(s_vertex_x), .s_vertex_y(s_vertex_y),
        .s_body_mass(s_body_mass), .s_last_vertex(s_last_vertex),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_centroid_x(m_centroid_x), .m_centroid_y(m_centroid_y),
        .m_inertia(m_inertia), .m_status(m_status)
    );

    always #5 aclk = ~aclk;

    // running polygon state of the predictor
    longint          p_first_x, p_first_y, p_prev_x, p_prev_y;
    int              p_count;
    longint          p_fan_area, p_wsum_x, p_wsum_y, p_inertia_sum;
    bit              p_overflow;

    mass_result_t    pending_results[$];
    int              failures = 0;
    int              vertices_sent = 0;
    int              burst_left = 0;
    longint unsigned cycle_count = 0;

    function automatic longint sat_acc(longint a, longint b, inout bit ov);
        if (b > 0 && a > 64'sh7FFF_FFFF_FFFF_FFFF - b) begin
            ov = 1'b1;
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        if (b < 0 && a < 64'sh8000_0000_0000_0000 - b) begin
            ov = 1'b1;
            return 64'sh8000_0000_0000_0000;
        end
        return a + b;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        longint unsigned m;
        m = v;
        return v < 0 ? -m : m;
    endfunction

    // signed origin-triangle contribution of edge b->c
    function automatic longint edge_moment(longint bx, longint by, longint cx, longint cy);
        longint          cr;
        longint unsigned q, t;
        cr = bx * cy - by * cx;
        q  = bx * bx + by * by + cx * cx + cy * cy + bx * cx + by * cy;
        t  = (magnitude(cr) * q) >> 16;
        return cr < 0 ? -longint'(t) : longint'(t);
    endfunction

    function automatic longint round_sat16(longint num, longint unsigned den);
        longint unsigned m, q, r;
        m = magnitude(num);
        q = m / den;
        r = m % den;
        if (r >= den - r) q++;
        if (num < 0) return q > 32768 ? -32768 : -longint'(q);
        return q > 32767 ? 32767 : longint'(q);
    endfunction

    task automatic clear_polygon();
        p_first_x = 0; p_first_y = 0; p_prev_x = 0; p_prev_y = 0;
        p_count = 0; p_fan_area = 0; p_wsum_x = 0; p_wsum_y = 0;
        p_inertia_sum = 0; p_overflow = 1'b0;
    endtask

    task automatic accumulate_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
                                     logic [31:0] mass, logic last);
        longint          x, y, cr, w, isum, cx, cy;
        longint unsigned f, d, s, q1, l, nc, m;
        bit              ov;
        mass_result_t    r;
        x = vx; y = vy; m = mass;
        if (p_count < VERTEX_LIMIT) begin
            if (p_count == 0) begin
                p_first_x = x; p_first_y = y;
            end else begin
                p_inertia_sum = sat_acc(p_inertia_sum,
                    edge_moment(p_prev_x, p_prev_y, x, y), p_overflow);
            end
            if (p_count >= 2) begin
                cr = (p_prev_x - p_first_x) * (y - p_first_y)
                   - (p_prev_y - p_first_y) * (x - p_first_x);
                w = cr < 0 ? -cr : cr;
                p_fan_area = sat_acc(p_fan_area, w, p_overflow);
                p_wsum_x = sat_acc(p_wsum_x, w * (p_first_x + p_prev_x + x), p_overflow);
                p_wsum_y = sat_acc(p_wsum_y, w * (p_first_y + p_prev_y + y), p_overflow);
            end
            p_prev_x = x; p_prev_y = y;
            p_count++;
        end
        if (!last) return;
        r.cx = '0; r.cy = '0; r.inertia = '0;
        if (p_count < 3) begin
            r.status = STATUS_FEW;
        end else if (p_fan_area == 0) begin
            r.status = STATUS_ZERO;
        end else begin
            ov = p_overflow;
            isum = sat_acc(p_inertia_sum,
                edge_moment(p_prev_x, p_prev_y, p_first_x, p_first_y), ov);
            f = p_fan_area;
            cx = round_sat16(p_wsum_x, 3 * f);
            cy = round_sat16(p_wsum_y, 3 * f);
            r.cx = 16'(cx); r.cy = 16'(cy);
            if (f >= 64'd1 << 44) ov = 1'b1;
            if (!ov) begin
                d = 6 * f;
                s = magnitude(isum);
                q1 = s / d;
                if (q1 >= 64'd1 << 15) begin
                    ov = 1'b1;
                end else begin
                    l = (q1 << 16) + ((s % d) << 16) / d;
                    if (l >= 64'd1 << 31) begin
                        ov = 1'b1;
                    end else begin
                        nc = cx * cx + cy * cy;
                        r.inertia = longint'(m * l) - longint'(m * nc);
                    end
                end
            end
            if (ov) begin
                r.inertia = SUM_MAX;
                r.status = STATUS_OVERFLOW;
            end else begin
                r.status = STATUS_OK;
            end
        end
        pending_results.insert(pending_results.size(), r);
        clear_polygon();
    endtask

    // called at a rising edge; returns at the edge where the vertex is taken
    task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y,
                               logic [31:0] mass, logic last);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_vertex_x    <= x;
        s_vertex_y    <= y;
        s_body_mass   <= mass;
        s_last_vertex <= last;
        do @(posedge aclk); while (!s_ready);
        accumulate_vertex(x, y, mass, last);
        vertices_sent++;
    endtask

    function automatic logic signed [15:0] clamp16(real v);
        if (v > 32767.0) return 16'sh7FFF;
        if (v < -32768.0) return 16'sh8000;
        return 16'($rtoi(v));
    endfunction

    // convex polygon around a centre, either winding
    task automatic send_convex(int n, real ccx, real ccy, real radius, logic [31:0] mass);
        real  a0, step, ang;
        bit   cw;
        a0   = $urandom_range(0, 999) * TWO_PI / 1000.0;
        step = TWO_PI / n;
        cw   = $urandom_range(0, 1);
        for (int i = 0; i < n; i++) begin
            ang = a0 + (cw ? -1.0 : 1.0) * step * (i + $urandom_range(0, 400) / 1000.0);
            send_vertex(clamp16(ccx + radius * $cos(ang)), clamp16(ccy + radius * $sin(ang)),
                        mass, i == n - 1);
        end
    endtask

    task automatic test_basic_shapes();
        // unit square, triangle, offset pentagon
        send_vertex(16'sd0, 16'sd0, 32'h0001_0000, 1'b0);
        send_vertex(16'sd256, 16'sd0, 32'h0001_0000, 1'b0);
        send_vertex(16'sd256, 16'sd256, 32'h0001_0000, 1'b0);
        send_vertex(16'sd0, 16'sd256, 32'h0001_0000, 1'b1);
        send_vertex(-16'sd512, -16'sd256, 32'h0002_8000, 1'b0);
        send_vertex(16'sd768, -16'sd256, 32'h0002_8000, 1'b0);
        send_vertex(16'sd0, 16'sd1024, 32'h0002_8000, 1'b1);
        send_convex(5, 3000.0, -2000.0, 900.0, 32'h0010_0000);
    endtask

    task automatic test_degenerate();
        // single vertex, two vertices, collinear points, repeated point
        send_vertex(16'sd100, 16'sd100, 32'h0001_0000, 1'b1);
        send_vertex(16'sd100, 16'sd100, 32'h0001_0000, 1'b0);
        send_vertex(-16'sd100, 16'sd50, 32'h0001_0000, 1'b1);
        send_vertex(16'sd0, 16'sd0, 32'h0001_0000, 1'b0);
        send_vertex(16'sd100, 16'sd100, 32'h0001_0000, 1'b0);
        send_vertex(16'sd300, 16'sd300, 32'h0001_0000, 1'b1);
        repeat (3) send_vertex(16'sd7, -16'sd7, 32'h0001_0000, 1'b0);
        send_vertex(16'sd7, -16'sd7, 32'h0001_0000, 1'b1);
    endtask

    task automatic test_field_extremes();
        // full-range corners overflow; zero and full mass
        send_vertex(16'sh8000, 16'sh8000, 32'hFFFF_FFFF, 1'b0);
        send_vertex(16'sh7FFF, 16'sh8000, 32'hFFFF_FFFF, 1'b0);
        send_vertex(16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF, 1'b0);
        send_vertex(16'sh8000, 16'sh7FFF, 32'hFFFF_FFFF, 1'b1);
        send_convex(6, 0.0, 0.0, 2000.0, 32'h0000_0000);
        send_convex(4, 0.0, 0.0, 2000.0, 32'hFFFF_FFFF);
    endtask

    task automatic test_excess_vertices();
        // the flag on an ignored vertex still closes the polygon
        send_convex(VERTEX_LIMIT, 0.0, 0.0, 5000.0, 32'h0003_0000);
        for (int i = 0; i < VERTEX_LIMIT + 4; i++)
            send_vertex(16'($urandom_range(0, 800) - 400), 16'($urandom_range(0, 800) - 400),
                        $urandom, i == VERTEX_LIMIT + 3);
    endtask

    task automatic test_random_polygons();
        int n;
        while (vertices_sent < 1850) begin
            case ($urandom_range(0, 9))
                0: begin
                    // noise: arbitrary points at full range
                    n = $urandom_range(1, 8);
                    for (int i = 0; i < n; i++)
                        send_vertex(16'($urandom), 16'($urandom), $urandom, i == n - 1);
                end
                1: send_convex($urandom_range(65, 70), $urandom_range(0, 20000) - 10000.0,
                               $urandom_range(0, 20000) - 10000.0,
                               $urandom_range(100, 8000), $urandom);
                2: send_convex($urandom_range(3, 12), 0.0, 0.0,
                               $urandom_range(20000, 46000), $urandom);
                default: send_convex($urandom_range(3, 10),
                                     $urandom_range(0, 40000) - 20000.0,
                                     $urandom_range(0, 40000) - 20000.0,
                                     $urandom_range(1, 6000), $urandom);
            endcase
        end
    endtask

    // result side: stall pattern plus checking against the oldest expectation
    always @(posedge aclk) begin
        mass_result_t e;
        int           phase;
        cycle_count <= cycle_count + 1;
        phase = int'((cycle_count / 97) % 4);
        case (phase)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ((cycle_count % 7) < 4);
        endcase
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction cx=%0d cy=%0d inertia=%0d status=%0d",
                         $time, m_centroid_x, m_centroid_y, m_inertia, m_status);
                failures++;
            end else begin
                e = pending_results.pop_front();
                if (m_centroid_x !== e.cx || m_centroid_y !== e.cy ||
                    m_inertia !== e.inertia || m_status !== e.status) begin
                    $display("%0t: mismatch expected cx=%0d cy=%0d inertia=%0d status=%0d",
                             $time, e.cx, e.cy, e.inertia, e.status);
                    $display("%0t:          actual   cx=%0d cy=%0d inertia=%0d status=%0d",
                             $time, m_centroid_x, m_centroid_y, m_inertia, m_status);
                    failures++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("polygon_mass_properties_tb: FAIL");
            $finish;
        end
    end

    initial begin
        clear_polygon();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_shapes();
        test_degenerate();
        test_field_extremes();
        test_excess_vertices();
        test_random_polygons();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (failures == 0) begin
            $display("polygon_mass_properties_tb: PASS");
        end else begin
            $display("polygon_mass_properties_tb: FAIL");
        end
        $finish;
    end

endmodule
